[src/serb_pkg.sv]
// Shared types and constants for the stereo elastic ring buffer.
// Holds the controller state type, the command struct and the fixed field widths.
// Depends on nothing; all other files use it by scoped names.
`timescale 1ns / 1ps

package serb_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FILL_W   = 32;
	localparam int CFG_W    = 15;

	localparam int unsigned CAPACITY_RESET = 12000;
	localparam logic [FILL_W-1:0] FILL_MAX = '1;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push;      // store the presented frame
		logic pop;       // resolve overrun, update slots and start the memory read
		logic load_out;  // move the read result into the output register
	} cmd_t;

endpackage

[src/serb_ctrl.sv]
// Controller state machine of the stereo elastic ring buffer.
// Drives the input and output handshakes and issues commands to serb_datapath.
// Depends on serb_pkg.
`timescale 1ns / 1ps

module serb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	output logic             out_valid,
	input  logic             out_ready,
	output serb_pkg::cmd_t   cmd
);

	serb_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;

	assign accept = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			serb_pkg::ST_IDLE: begin
				if (accept && action == serb_pkg::ACT_POP) begin
					state_d = serb_pkg::ST_READ;
				end
			end
			serb_pkg::ST_READ: begin
				if (!out_valid_q || out_ready) begin
					state_d = serb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = serb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.push     = 1'b0;
		cmd.pop      = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			serb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.push = in_valid && action == serb_pkg::ACT_PUSH;
				cmd.pop  = in_valid && action == serb_pkg::ACT_POP;
			end
			serb_pkg::ST_READ: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= serb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/serb_datapath.sv]
// Datapath of the stereo elastic ring buffer: sample memory, slot pointers,
// fill level, capacity register and output register.
// Depends on serb_pkg; commanded by serb_ctrl.
`timescale 1ns / 1ps

module serb_datapath #(
	parameter int DEPTH = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  serb_pkg::cmd_t                cmd,
	input  logic                          cfg_wr_en,
	input  logic [serb_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic [serb_pkg::SAMPLE_W-1:0] first_sample,
	input  logic [serb_pkg::SAMPLE_W-1:0] second_sample,
	input  logic                          is_stereo,
	input  logic                          first_of_block,
	output logic [serb_pkg::SAMPLE_W-1:0] left_sample,
	output logic [serb_pkg::SAMPLE_W-1:0] right_sample,
	output logic                          was_silence,
	output logic                          did_resync
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WORD_W = 2 * serb_pkg::SAMPLE_W;
	localparam int CAP_RESET_I = (serb_pkg::CAPACITY_RESET > DEPTH) ? DEPTH :
		((serb_pkg::CAPACITY_RESET < 2) ? 2 : serb_pkg::CAPACITY_RESET);
	localparam logic [CW-1:0] CAP_RESET = CW'(CAP_RESET_I);

	logic [WORD_W-1:0] sample_mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_s1;
	logic              silence_s1;
	logic              resync_s1;

	logic [CW-1:0]                 cap_q;
	logic [SW-1:0]                 wr_slot_q;
	logic [SW-1:0]                 rd_slot_q;
	logic [serb_pkg::FILL_W-1:0]   fill_q;

	logic [serb_pkg::SAMPLE_W-1:0] left_q, right_q;
	logic                          silence_q, resync_q;

	logic [CW-1:0]               cap_half;
	logic [CW-1:0]               wr_ext;
	logic [SW-1:0]               resync_slot;
	logic                        resync;
	logic [SW-1:0]               rd_eff;
	logic [serb_pkg::FILL_W-1:0] fill_eff;
	logic                        silence;
	logic [31:0]                 cfg_ext;
	logic [CW-1:0]               cap_new;
	logic [serb_pkg::SAMPLE_W-1:0] right_in;

	function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s, logic [CW-1:0] cap);
		logic [CW:0] n;
		n = (CW+1)'(s) + (CW+1)'(1);
		return (n >= (CW+1)'(cap)) ? '0 : SW'(n);
	endfunction

	// Overrun resolution: half a capacity behind the write slot, modulo capacity.
	assign cap_half = cap_q >> 1;
	assign wr_ext   = CW'(wr_slot_q);
	assign resync_slot = (wr_ext >= cap_half) ? SW'(wr_ext - cap_half)
	                                          : SW'(wr_ext + (cap_q - cap_half));
	assign resync   = first_of_block && (fill_q > serb_pkg::FILL_W'(cap_q));
	assign rd_eff   = resync ? resync_slot : rd_slot_q;
	assign fill_eff = resync ? serb_pkg::FILL_W'(cap_half) : fill_q;
	assign silence  = (fill_eff == '0);

	assign cfg_ext = 32'(cfg_wr_data);
	assign cap_new = (cfg_ext < 32'd2) ? CW'(2) :
	                 (cfg_ext > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_wr_data);

	assign right_in = is_stereo ? second_sample : first_sample;

	// Sample memory, one access a cycle, registered read data.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			sample_mem_q[wr_slot_q] <= {right_in, first_sample};
		end
		if (cmd.pop) begin
			rd_data_s1 <= sample_mem_q[rd_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			silence_s1 <= silence;
			resync_s1  <= resync;
		end
		if (cmd.load_out) begin
			left_q    <= silence_s1 ? '0 : rd_data_s1[serb_pkg::SAMPLE_W-1:0];
			right_q   <= silence_s1 ? '0 : rd_data_s1[WORD_W-1:serb_pkg::SAMPLE_W];
			silence_q <= silence_s1;
			resync_q  <= resync_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			fill_q    <= '0;
		end else if (cfg_wr_en) begin
			cap_q     <= cap_new;
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			fill_q    <= '0;
		end else if (cmd.push) begin
			wr_slot_q <= next_slot(wr_slot_q, cap_q);
			if (fill_q != serb_pkg::FILL_MAX) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (cmd.pop) begin
			if (silence) begin
				rd_slot_q <= rd_eff;
				fill_q    <= fill_eff;
			end else begin
				rd_slot_q <= next_slot(rd_eff, cap_q);
				fill_q    <= fill_eff - 1'b1;
			end
		end
	end

	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign was_silence  = silence_q;
	assign did_resync   = resync_q;

	a_rd_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(rd_slot_q) < cap_q)
		else $error("read slot beyond capacity");

	a_wr_slot_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(wr_slot_q) < cap_q)
		else $error("write slot beyond capacity");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q >= CW'(2) && cap_q <= CW'(DEPTH))
		else $error("capacity outside its clamped range");

	a_resync_not_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && resync |=> !silence_s1)
		else $error("resynchronised pop returned silence");

endmodule

[src/stereo_elastic_ring_buffer_unit.sv]
// Top level of the stereo elastic ring buffer.
// Joins the controller serb_ctrl and the datapath serb_datapath; uses serb_pkg.
//
//   Channel  | Handshake           | Carries
//   ---------+---------------------+-------------------------------------------------
//   in       | in_valid / in_ready | action, first_sample, second_sample,
//            |                     | is_stereo, first_of_block
//   out      | out_valid/out_ready | left_sample, right_sample, was_silence, did_resync
//   cfg      | cfg_wr_en           | cfg_wr_data (capacity in use, clamped to 2..DEPTH)
//
// A push item is done once it is accepted, and the next item may follow in the next cycle.
// A pop item passes from IDLE to READ, as the sample memory has a registered read port;
// in_ready is low in READ and stays low while the output register is full and not read.
// A push is taken while a finished result still waits in the output register.
// Reset returns the pointers and fill level to zero; the memory needs no clearing pass,
// since only a non-silent pop uses its read data, and it reads a slot written since reset.
`timescale 1ns / 1ps

module stereo_elastic_ring_buffer_unit #(
	parameter int DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] first_sample,
	input  logic [31:0] second_sample,
	input  logic        is_stereo,
	input  logic        first_of_block,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] left_sample,
	output logic [31:0] right_sample,
	output logic        was_silence,
	output logic        did_resync,

	input  logic        cfg_wr_en,
	input  logic [14:0] cfg_wr_data
);

	// Commands from the controller to the datapath.
	serb_pkg::cmd_t cmd;

	// The controller owns the handshakes and sequences each pop through the
	// memory read; the datapath does all the pointer and fill arithmetic.
	serb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath resolves an overrun at the start of a block, updates the slots and
	// the saturating fill level, and returns silence when the ring is empty.
	serb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.first_sample   (first_sample),
		.second_sample  (second_sample),
		.is_stereo      (is_stereo),
		.first_of_block (first_of_block),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.was_silence    (was_silence),
		.did_resync     (did_resync)
	);

endmodule

[sim/tb_stereo_elastic_ring_buffer_unit.sv]
// Self-checking testbench for the stereo elastic ring buffer unit.
// Depends on serb_pkg and stereo_elastic_ring_buffer_unit, which needs serb_ctrl and serb_datapath.
// A tracker class predicts every popped frame and checks the output channel against it.
`timescale 1ns / 1ps

module tb_stereo_elastic_ring_buffer_unit;

	localparam int SAMPLE_W     = serb_pkg::SAMPLE_W;
	localparam int FILL_W       = serb_pkg::FILL_W;
	localparam int CFG_W        = serb_pkg::CFG_W;

	localparam int RING_DEPTH   = 16384;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CALM_ITEMS   = 150;   // the tail of the random part runs without idling
	localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
	localparam int SETTLE_CYC   = 4;     // idle time before a capacity write, for a trailing item to land

	// One expected pop result, in the order of the output ports.
	typedef struct {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                silence;
		logic                resync;
	} pop_frame_t;

	// The tracker keeps its own copy of the ring: the sample store, both slots,
	// the fill level and the capacity in use. Every accepted item updates it, and
	// every accepted pop leaves one expected frame in the queue.
	class ring_tracker;
		bit [63:0]         store [RING_DEPTH];
		int unsigned       capacity;
		int unsigned       wr_slot;
		int unsigned       rd_slot;
		bit [FILL_W-1:0]   fill;
		pop_frame_t        due_pops [$];
		int                mismatches;

		function new();
			foreach (store[i])
				store[i] = '0;
			mismatches = 0;
			set_capacity(CFG_W'(serb_pkg::CAPACITY_RESET));
		endfunction

		// A capacity write clamps the value and empties the ring, keeping the samples.
		function void set_capacity(logic [CFG_W-1:0] value);
			if (value < 2)
				capacity = 2;
			else if (value > RING_DEPTH)
				capacity = RING_DEPTH;
			else
				capacity = value;
			wr_slot = 0;
			rd_slot = 0;
			fill = '0;
		endfunction

		function int unsigned next_slot(int unsigned slot);
			return (slot + 1 >= capacity) ? 0 : slot + 1;
		endfunction

		function int pending();
			return due_pops.size();
		endfunction

		function void note_frame(logic act, logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second,
				logic stereo, logic block_start);
			pop_frame_t  frame;
			int unsigned half;
			logic [SAMPLE_W-1:0] right;
			if (act == serb_pkg::ACT_PUSH) begin
				right = stereo ? second : first;
				store[wr_slot] = {right, first};
				wr_slot = next_slot(wr_slot);
				if (fill != serb_pkg::FILL_MAX)
					fill++;
				return;
			end
			frame.resync = 1'b0;
			// On a block start an overrun pulls the read slot to half a ring behind live.
			if (block_start && fill > capacity) begin
				half = capacity / 2;
				rd_slot = (wr_slot >= half) ? wr_slot - half : wr_slot + capacity - half;
				fill = half;
				frame.resync = 1'b1;
			end
			if (fill == 0) begin
				frame.left = '0;
				frame.right = '0;
				frame.silence = 1'b1;
			end else begin
				frame.left = store[rd_slot][31:0];
				frame.right = store[rd_slot][63:32];
				frame.silence = 1'b0;
				rd_slot = next_slot(rd_slot);
				fill--;
			end
			due_pops.insert(due_pops.size(), frame);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_pop(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right, logic silence,
				logic resync);
			pop_frame_t want;
			if (due_pops.size() == 0) begin
				report("pop result arrived with none outstanding");
				return;
			end
			want = due_pops.pop_front();
			if (left !== want.left)
				report($sformatf("left_sample %h, expected %h", left, want.left));
			if (right !== want.right)
				report($sformatf("right_sample %h, expected %h", right, want.right));
			if (silence !== want.silence)
				report($sformatf("was_silence %b, expected %b", silence, want.silence));
			if (resync !== want.resync)
				report($sformatf("did_resync %b, expected %b", resync, want.resync));
		endtask

		task check_leftovers();
			if (due_pops.size() != 0)
				report($sformatf("%0d pop results never arrived", due_pops.size()));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [SAMPLE_W-1:0] first_sample;
	logic [SAMPLE_W-1:0] second_sample;
	logic                is_stereo;
	logic                first_of_block;
	logic                out_valid;
	logic                out_ready;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] right_sample;
	logic                was_silence;
	logic                did_resync;
	logic                cfg_wr_en;
	logic [CFG_W-1:0]    cfg_wr_data;

	ring_tracker tracker;
	bit          idling_on;
	int          random_done;

	stereo_elastic_ring_buffer_unit #(
		.DEPTH(RING_DEPTH)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.first_sample   (first_sample),
		.second_sample  (second_sample),
		.is_stereo      (is_stereo),
		.first_of_block (first_of_block),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.was_silence    (was_silence),
		.did_resync     (did_resync),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offers one item at a falling edge, after an optional idle burst, and holds it
	// until a rising edge sees in_ready. Only then does the tracker learn of it.
	task automatic send_frame(logic act, logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second,
			logic stereo, logic block_start);
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		first_sample <= first;
		second_sample <= second;
		is_stereo <= stereo;
		first_of_block <= block_start;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_frame(act, first, second, stereo, block_start);
	endtask

	task automatic push_frame(logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second, logic stereo);
		send_frame(serb_pkg::ACT_PUSH, first, second, stereo, 1'($urandom_range(0, 1)));
	endtask

	// The sample fields of a pop are ignored, so they carry noise.
	task automatic pop_frame(logic block_start);
		send_frame(serb_pkg::ACT_POP, $urandom, $urandom, 1'($urandom_range(0, 1)), block_start);
	endtask

	// Stops offering items and waits until every outstanding pop has been seen.
	task automatic drain_pops();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// The capacity may only change while the block is idle, so drain first and
	// give a trailing push time to land before the write.
	task automatic write_capacity(logic [CFG_W-1:0] value);
		drain_pops();
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_capacity(value);
	endtask

	// Mostly small rings so that overruns and wraps are frequent, with the clamped
	// extremes and an occasional large ring mixed in.
	function automatic logic [CFG_W-1:0] pick_capacity();
		case ($urandom_range(0, 19))
			0:       return CFG_W'($urandom_range(0, 1));
			1:       return CFG_W'(2);
			2:       return CFG_W'(3);
			3:       return CFG_W'($urandom_range(RING_DEPTH, 32767));
			4:       return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(2, 24));
		endcase
	endfunction

	// The receiver stalls in bursts while idling is on and is always ready otherwise.
	initial begin : out_ready_driver
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 14) - 1;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_pop(left_sample, right_sample, was_silence, did_resync);
	end

	// Any handshake on either channel counts as progress; a long silence means a hang.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("stereo_elastic_ring_buffer_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		int phase_len;
		int push_pct;
		int fob_pct;
		tracker = new();
		idling_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = serb_pkg::ACT_PUSH;
		first_sample = '0;
		second_sample = '0;
		is_stereo = 1'b0;
		first_of_block = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity: a pop on an empty ring gives silence
		// even at a block start, then extreme sample patterns, mono duplication and
		// ignored block-start flags on pushes.
		pop_frame(1'b1);
		push_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		push_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		push_frame(32'h8000_0001, 32'h7FFF_FFFE, 1'b1);
		pop_frame(1'b1);
		pop_frame(1'b0);
		pop_frame(1'b1);
		pop_frame(1'b0);

		// A zero capacity clamps to the smallest ring of two frames. A third push
		// overwrites the oldest slot, and a pop without a block start does not resync.
		write_capacity(CFG_W'(0));
		push_frame($urandom, $urandom, 1'b1);
		push_frame($urandom, $urandom, 1'b0);
		push_frame($urandom, $urandom, 1'b1);
		pop_frame(1'b0);
		push_frame($urandom, $urandom, 1'b1);
		// Fill is above capacity here, so a block start resyncs and then pops.
		pop_frame(1'b1);
		pop_frame(1'b1);

		// An odd capacity, overrun with the write slot at or past half the ring.
		write_capacity(CFG_W'(5));
		repeat (7) push_frame($urandom, $urandom, 1'($urandom_range(0, 1)));
		pop_frame(1'b1);
		pop_frame(1'b0);

		// The sender waits here until every result is in.
		drain_pops();

		// The all-ones register value clamps to the full depth; a short run at that
		// size stays well below the overrun threshold.
		write_capacity(CFG_W'(32767));
		repeat (6) push_frame($urandom, $urandom, 1'($urandom_range(0, 1)));
		pop_frame(1'b1);
		pop_frame(1'b0);
		pop_frame(1'b1);

		// Random phases, each at a freshly chosen capacity and with its own balance
		// of pushes and pops, so that some phases overrun and others starve.
		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			write_capacity(pick_capacity());
			phase_len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0:       push_pct = 70;
				1:       push_pct = 50;
				default: push_pct = 35;
			endcase
			fob_pct = $urandom_range(10, 50);
			repeat (phase_len) begin
				if (random_done >= RANDOM_ITEMS - CALM_ITEMS)
					idling_on = 1'b0;
				if (idling_on && $urandom_range(0, 99) == 0)
					drain_pops();
				if ($urandom_range(0, 99) < push_pct)
					push_frame($urandom, $urandom, 1'($urandom_range(0, 1)));
				else
					pop_frame(1'($urandom_range(0, 99) < fob_pct));
				random_done++;
			end
		end

		drain_pops();
		repeat (8) @(posedge clk);
		tracker.check_leftovers();
		if (tracker.mismatches == 0)
			$display("stereo_elastic_ring_buffer_unit regression: pass");
		else
			$display("stereo_elastic_ring_buffer_unit regression: fail");
		$finish;
	end

endmodule
